>>> sv/crls_pkg.sv
// ----------------------------------------------------------------------------
// Clip rectangle list package
// Shared constants, command and result codes, and transaction payload types.
// ----------------------------------------------------------------------------
`default_nettype none

package crls_pkg;

   localparam int MaxRects  = 32;
   localparam int CoordBits = 16;
   localparam int IdxBits   = $clog2(MaxRects);
   localparam int CntBits   = $clog2(MaxRects + 1);

   typedef logic signed [CoordBits-1:0] coord_type;

   typedef enum logic [1:0] {
      CMD_CLEAR = 2'd0,
      CMD_ADD   = 2'd1,
      CMD_SUB   = 2'd2,
      CMD_DUMP  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_DONE  = 2'd0,
      KIND_OVF   = 2'd1,
      KIND_ENTRY = 2'd2
   } kind_type;

   typedef struct packed {
      coord_type l;
      coord_type t;
      coord_type r;
      coord_type b;
   } box_type;

   typedef struct packed {
      logic [1:0]         cmd;
      logic signed [15:0] rect_x;
      logic signed [15:0] rect_y;
      logic [14:0]        rect_width;
      logic [14:0]        rect_height;
   } req_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [5:0]         entry_count;
      logic signed [15:0] entry_x;
      logic signed [15:0] entry_y;
      logic [14:0]        entry_width;
      logic [14:0]        entry_height;
      logic               last;
   } rsp_type;

endpackage

`default_nettype wire

>>> sv/clip_rect_list_subtract.sv
// Operation: clear responds directly; subtract and add first copy the entries that the given
// rectangle does not overlap into the work list, then cut each overlapped entry one edge per
// step, write the work list back and, for add, append the rectangle; on an empty list they go
// straight to the append. Dump gives one entry per cycle while the receiver is ready.
// Commands: one at a time, with a single shared cut unit and one read port per list
// memory. A waiting result sits in the output register without blocking input.
// Reset: synchronous, active high; the count and sequencer clear, the list
// memory keeps its contents and entries past the count are never used.
// ----------------------------------------------------------------------------
// Clip rectangle list top level
// Keeps a bounded list of clip rectangles and subtracts, adds or dumps them.
// ----------------------------------------------------------------------------
`default_nettype none

module clip_rect_list_subtract
   import crls_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b00000001,
      ST_KEEP  = 8'b00000010,
      ST_CUTRD = 8'b00000100,
      ST_CUT   = 8'b00001000,
      ST_COPY  = 8'b00010000,
      ST_APP   = 8'b00100000,
      ST_DUMP  = 8'b01000000,
      ST_RESP  = 8'b10000000
   } state_type;

   localparam int WBits = CoordBits + 1;
   localparam coord_type CoordMin = {1'b1, {(CoordBits-1){1'b0}}};
   localparam coord_type CoordMax = {1'b0, {(CoordBits-1){1'b1}}};

   // Store and work list, one write and one read port each.
   box_type store_mem [MaxRects];
   box_type work_mem  [MaxRects];

   state_type           state_ff, state_in;
   logic [CntBits-1:0]  count_ff, count_in;
   logic [CntBits-1:0]  idx_ff, idx_in;
   logic [CntBits-1:0]  wn_ff, wn_in;
   logic [2:0]          step_ff, step_in;
   logic                ovf_ff, ovf_in;
   logic                add_ff, add_in;
   box_type             g_ff, g_in;
   box_type             t_ff, t_in;
   box_type             rd_ff;
   box_type             wrd_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   // Clip the given rectangle to the coordinate window.
   logic signed [WBits:0] gx, gy, gr, gb;
   localparam logic signed [WBits:0] CMax = (WBits+1)'((1 << (CoordBits-1)) - 1);
   always_comb begin
      gx = (WBits+1)'(req_data.rect_x);
      gy = (WBits+1)'(req_data.rect_y);
      gr = gx + $signed({1'b0, req_data.rect_width}) - 1;
      gb = gy + $signed({1'b0, req_data.rect_height}) - 1;
      if (gr > CMax) gr = CMax;
      if (gb > CMax) gb = CMax;
   end
   wire g_empty = (gx > gr) || (gy > gb);

   function automatic logic overlap(box_type a, box_type c);
      return !(a.l > a.r || a.t > a.b) &&
             a.l <= c.r && c.l <= a.r && a.t <= c.b && c.t <= a.b;
   endfunction

   // Shared cut unit: one edge of the given rectangle per step.
   // A cut on the outermost coordinate leaves nothing on the far side.
   logic    cut_hit;
   logic    cut_wrap;
   box_type piece, t_next;
   always_comb begin
      cut_hit  = 1'b0;
      cut_wrap = 1'b0;
      piece    = t_ff;
      t_next   = t_ff;
      case (step_ff[1:0])
         2'd0: begin
            cut_hit = g_ff.l >= t_ff.l && g_ff.l <= t_ff.r;
            cut_wrap = g_ff.l == CoordMin;
            piece.r = g_ff.l - 1'b1;
            t_next.l = g_ff.l;
         end
         2'd1: begin
            cut_hit = g_ff.t >= t_ff.t && g_ff.t <= t_ff.b;
            cut_wrap = g_ff.t == CoordMin;
            piece.b = g_ff.t - 1'b1;
            t_next.t = g_ff.t;
         end
         2'd2: begin
            cut_hit = g_ff.r >= t_ff.l && g_ff.r <= t_ff.r;
            cut_wrap = g_ff.r == CoordMax;
            piece.l = g_ff.r + 1'b1;
            t_next.r = g_ff.r;
         end
         default: begin
            cut_hit = g_ff.b >= t_ff.t && g_ff.b <= t_ff.b;
            cut_wrap = g_ff.b == CoordMax;
            piece.t = g_ff.b + 1'b1;
            t_next.b = g_ff.b;
         end
      endcase
      if (!cut_hit) t_next = t_ff;
   end
   wire piece_empty = cut_wrap || (piece.l > piece.r) || (piece.t > piece.b);

   wire rsp_free = !rsp_valid_ff || rsp_ready;
   wire last_idx = (idx_ff + 1'b1) >= count_ff;

   logic    wk_we, st_we;
   logic [IdxBits-1:0] wk_wa, st_wa;
   box_type wk_wd, st_wd;
   logic [IdxBits-1:0] rd_addr;

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      wn_in        = wn_ff;
      step_in      = step_ff;
      ovf_in       = ovf_ff;
      add_in       = add_ff;
      g_in         = g_ff;
      t_in         = t_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      wk_we = 1'b0; wk_wa = wn_ff[IdxBits-1:0]; wk_wd = rd_ff;
      st_we = 1'b0; st_wa = idx_ff[IdxBits-1:0]; st_wd = wrd_ff;
      rd_addr = idx_ff[IdxBits-1:0];
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            idx_in = '0;
            wn_in  = '0;
            ovf_in = 1'b0;
            rd_addr = '0;
            if (req_valid) begin
               g_in   = '{CoordBits'(gx), CoordBits'(gy), CoordBits'(gr), CoordBits'(gb)};
               add_in = req_data.cmd == CMD_ADD;
               case (req_data.cmd)
                  CMD_CLEAR: begin
                     count_in = '0;
                     state_in = ST_RESP;
                  end
                  CMD_DUMP: begin
                     state_in = (count_ff == 0) ? ST_RESP : ST_DUMP;
                  end
                  default: begin
                     state_in = (g_empty) ? ST_RESP :
                                (count_ff == 0) ? ST_APP : ST_KEEP;
                  end
               endcase
            end
         end
         ST_KEEP: begin
            // Pass one: copy untouched entries into the work list.
            rd_addr = idx_ff[IdxBits-1:0] + 1'b1;
            if (!overlap(rd_ff, g_ff)) begin
               wk_we = 1'b1;
               wn_in = wn_ff + 1'b1;
            end
            idx_in = idx_ff + 1'b1;
            if (last_idx) begin
               idx_in = '0;
               rd_addr = '0;
               state_in = ST_CUTRD;
            end
         end
         ST_CUTRD: begin
            // Pass two: fetch the next stored entry and test it.
            if (overlap(rd_ff, g_ff)) begin
               t_in = rd_ff;
               step_in = '0;
               state_in = ST_CUT;
            end else if (last_idx) begin
               idx_in = '0;
               step_in = '0;
               state_in = ST_COPY;
            end else begin
               idx_in = idx_ff + 1'b1;
               rd_addr = idx_ff[IdxBits-1:0] + 1'b1;
               state_in = ST_CUTRD;
            end
         end
         ST_CUT: begin
            if (cut_hit && !piece_empty) begin
               if (wn_ff >= CntBits'(MaxRects)) ovf_in = 1'b1;
               else begin
                  wk_we = 1'b1; wk_wd = piece; wn_in = wn_ff + 1'b1;
               end
            end
            t_in = t_next;
            step_in = step_ff + 1'b1;
            if (step_ff == 3'd3) begin
               if (last_idx) begin
                  idx_in = '0;
                  step_in = '0;
                  state_in = ST_COPY;
               end else begin
                  idx_in = idx_ff + 1'b1;
                  rd_addr = idx_ff[IdxBits-1:0] + 1'b1;
                  state_in = ST_CUTRD;
               end
            end
         end
         ST_COPY: begin
            // Write the work list back; wrd_ff holds the work entry at the index, read a step ahead.
            rd_addr = idx_ff[IdxBits-1:0];
            if (step_ff != 3'd4) begin
               step_in = 3'd4;
            end else begin
               st_we = idx_ff < wn_ff;
               st_wa = idx_ff[IdxBits-1:0];
               idx_in = idx_ff + 1'b1;
               rd_addr = idx_ff[IdxBits-1:0] + 1'b1;
               if (idx_ff + 1'b1 >= wn_ff) begin
                  count_in = wn_ff;
                  state_in = ST_APP;
               end
            end
         end
         ST_APP: begin
            count_in = (state_ff == ST_APP && idx_ff == '0 && wn_ff == '0) ?
                       wn_ff : count_ff;
            if (add_ff) begin
               if (count_in >= CntBits'(MaxRects)) ovf_in = 1'b1;
               else begin
                  st_we = 1'b1; st_wa = count_in[IdxBits-1:0]; st_wd = g_ff;
                  count_in = count_in + 1'b1;
               end
            end
            state_in = ST_RESP;
         end
         ST_DUMP: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_in = '{KIND_ENTRY, 6'(count_ff), rd_ff.l, rd_ff.t,
                          15'(rd_ff.r - rd_ff.l + 1'b1),
                          15'(rd_ff.b - rd_ff.t + 1'b1), last_idx};
               idx_in = idx_ff + 1'b1;
               rd_addr = idx_ff[IdxBits-1:0] + 1'b1;
               if (last_idx) state_in = ST_IDLE;
            end
         end
         default: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_in = '{ovf_ff ? KIND_OVF : KIND_DONE, 6'(count_ff),
                          '0, '0, '0, '0, 1'b1};
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   // In pass one the read of the following entry must be ready next cycle.
   always_ff @(posedge clock) begin
      if (wk_we) work_mem[wk_wa] <= wk_wd;
      if (st_we) store_mem[st_wa] <= st_wd;
      rd_ff  <= store_mem[rd_addr];
      wrd_ff <= work_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= (state_ff == ST_IDLE) ? '0 : step_in;
      end
      idx_ff <= idx_in;
      wn_ff  <= wn_in;
      ovf_ff <= ovf_in;
      add_ff <= add_in;
      g_ff   <= g_in;
      t_ff   <= t_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntBits'(MaxRects)) else $error("count beyond capacity");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_ready) else $error("ready while busy");
   a_work_bound: assert property (@(posedge clock) disable iff (reset)
      wn_ff <= CntBits'(MaxRects)) else $error("work list overrun");
`endif

endmodule

`default_nettype wire

>>> bench/tb_clip_rect_list_subtract.sv
// ----------------------------------------------------------------------------
// Clip rectangle list testbench
// Drives clear, add, subtract and dump transactions through the request
// channel, predicts every response with a behavioural copy of the list, and
// compares each whole response, with random idling on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_clip_rect_list_subtract;
   timeunit 1ns;
   timeprecision 1ps;

   import crls_pkg::*;

   localparam int WatchLimit = 20000;
   localparam int RandItems  = 160;
   localparam int LongHold   = 400;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   clip_rect_list_subtract DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #4 clock = ~clock;

   // Predicted list contents and expected responses.
   int      clip_l[MaxRects], clip_t[MaxRects], clip_r[MaxRects], clip_b[MaxRects];
   int      clip_n;
   rsp_type rsp_expected[$];
   int      errors = 0;
   bit      idle_off = 1'b0;
   bit      hold_rsp = 1'b0;
   int      quiet = 0;

   function automatic rsp_type make_rsp(logic [1:0] kind, int l, int t, int r, int b,
                                        bit has_box, bit last);
      rsp_type o;
      o = '0;
      o.kind = kind;
      o.entry_count = clip_n[5:0];
      if (has_box) begin
         o.entry_x = l[15:0];
         o.entry_y = t[15:0];
         o.entry_width = 15'(r - l + 1);
         o.entry_height = 15'(b - t + 1);
      end
      o.last = last;
      return o;
   endfunction

   // Models a request: cuts overlapped entries, queues expected responses.
   task automatic apply_request(req_type q);
      int gl, gt, gr, gb, i, n, tl, tt, tr, tb;
      int nl[MaxRects], nt[MaxRects], nr[MaxRects], nb[MaxRects];
      bit ovf, hit;
      bit [3:0] cut;
      int pl[4], pt[4], pr[4], pb[4];
      ovf = 0;
      gl = int'(q.rect_x);
      gt = int'(q.rect_y);
      gr = gl + int'(q.rect_width) - 1;
      gb = gt + int'(q.rect_height) - 1;
      if (gr > 32767) gr = 32767;
      if (gb > 32767) gb = 32767;
      case (cmd_type'(q.cmd))
         CMD_CLEAR: clip_n = 0;
         CMD_DUMP: begin
            if (clip_n == 0) begin
               rsp_expected.push_back(make_rsp(KIND_DONE, 0, 0, 0, 0, 0, 1));
               return;
            end
            for (i = 0; i < clip_n; i++)
               rsp_expected.push_back(make_rsp(KIND_ENTRY, clip_l[i], clip_t[i],
                  clip_r[i], clip_b[i], 1, i + 1 == clip_n));
            return;
         end
         default: begin
            if (gl <= gr && gt <= gb) begin
               n = 0;
               for (i = 0; i < clip_n; i++) begin
                  hit = clip_l[i] <= gr && gl <= clip_r[i] &&
                        clip_t[i] <= gb && gt <= clip_b[i];
                  if (!hit) begin
                     nl[n] = clip_l[i]; nt[n] = clip_t[i];
                     nr[n] = clip_r[i]; nb[n] = clip_b[i]; n++;
                  end
               end
               for (i = 0; i < clip_n; i++) begin
                  hit = clip_l[i] <= gr && gl <= clip_r[i] &&
                        clip_t[i] <= gb && gt <= clip_b[i];
                  if (hit) begin
                     tl = clip_l[i]; tt = clip_t[i]; tr = clip_r[i]; tb = clip_b[i];
                     cut = '0;
                     if (gl >= tl && gl <= tr) begin
                        cut[0] = 1; pl[0] = tl; pt[0] = tt; pr[0] = gl - 1; pb[0] = tb;
                        tl = gl;
                     end
                     if (gt >= tt && gt <= tb) begin
                        cut[1] = 1; pl[1] = tl; pt[1] = tt; pr[1] = tr; pb[1] = gt - 1;
                        tt = gt;
                     end
                     if (gr >= tl && gr <= tr) begin
                        cut[2] = 1; pl[2] = gr + 1; pt[2] = tt; pr[2] = tr; pb[2] = tb;
                        tr = gr;
                     end
                     if (gb >= tt && gb <= tb) begin
                        cut[3] = 1; pl[3] = tl; pt[3] = gb + 1; pr[3] = tr; pb[3] = tb;
                        tb = gb;
                     end
                     for (int k = 0; k < 4; k++)
                        if (cut[k] && pl[k] <= pr[k] && pt[k] <= pb[k]) begin
                           if (n >= MaxRects) ovf = 1;
                           else begin
                              nl[n] = pl[k]; nt[n] = pt[k];
                              nr[n] = pr[k]; nb[n] = pb[k]; n++;
                           end
                        end
                  end
               end
               for (i = 0; i < n; i++) begin
                  clip_l[i] = nl[i]; clip_t[i] = nt[i];
                  clip_r[i] = nr[i]; clip_b[i] = nb[i];
               end
               clip_n = n;
               if (q.cmd == CMD_ADD) begin
                  if (clip_n >= MaxRects) ovf = 1;
                  else begin
                     clip_l[clip_n] = gl; clip_t[clip_n] = gt;
                     clip_r[clip_n] = gr; clip_b[clip_n] = gb; clip_n++;
                  end
               end
            end
         end
      endcase
      rsp_expected.push_back(make_rsp(ovf ? KIND_OVF : KIND_DONE, 0, 0, 0, 0, 0, 1));
   endtask

   function automatic req_type mk(cmd_type c, int x, int y, int w, int h);
      req_type q;
      q.cmd = c; q.rect_x = x[15:0]; q.rect_y = y[15:0];
      q.rect_width = w[14:0]; q.rect_height = h[14:0];
      return q;
   endfunction

   // Mostly small rectangles in a small area so that overlaps are common.
   function automatic req_type rand_req();
      req_type q;
      int r;
      r = $urandom_range(0, 99);
      if (r < 3) q = mk(CMD_CLEAR, 0, 0, 0, 0);
      else if (r < 15) q = mk(CMD_DUMP, 0, 0, 0, 0);
      else if (r < 85)
         q = mk(r < 55 ? CMD_ADD : CMD_SUB, $urandom_range(0, 60) - 30,
                $urandom_range(0, 60) - 30, $urandom_range(0, 40),
                $urandom_range(0, 40));
      else q = req_type'({$urandom, $urandom});
      return q;
   endfunction

   // Sends one request transaction; valid stays high into the next one
   // unless an idle gap comes first.
   task automatic send(req_type q, bit allow_idle);
      if (allow_idle && !idle_off && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
      req_data <= q;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      apply_request(q);
      @(negedge clock);
   endtask

   // Receiver: random back-pressure bursts, or a long hold when asked.
   always @(negedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else if (hold_rsp) rsp_ready <= 1'b0;
      else if (!idle_off && $urandom_range(0, 7) == 0) begin
         rsp_ready <= 1'b0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
         rsp_ready <= 1'b1;
      end else rsp_ready <= 1'b1;
   end

   // Response checking at the rising edge.
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (rsp_expected.size() == 0) begin
            $display("%0t: unexpected response %h", $realtime, rsp_data);
            errors++;
         end else begin
            e = rsp_expected.pop_front();
            if (rsp_data !== e) begin
               $display("%0t: mismatch expected %h actual %h", $realtime, e, rsp_data);
               errors++;
            end
         end
      end
   end

   // Watchdog on cycles without any accepted transaction.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= WatchLimit) begin
         $display("tb_clip_rect_list_subtract: FAIL");
         $finish;
      end
   end

   req_type directed[$];

   initial begin
      rsp_type fixed;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // Directed table: dump of an empty list after reset, extremes, empty
      // rectangles and clipping at the coordinate window.
      directed = '{
         mk(CMD_DUMP, 0, 0, 0, 0),
         mk(CMD_ADD, 5, 5, 0, 10),
         mk(CMD_SUB, 5, 5, 10, 0),
         mk(CMD_ADD, -32768, -32768, 32767, 32767),
         mk(CMD_ADD, 32767, 32767, 32767, 32767),
         mk(CMD_ADD, -100, -100, 200, 200),
         mk(CMD_DUMP, 0, 0, 0, 0),
         mk(CMD_SUB, -10, -10, 20, 20),
         mk(CMD_DUMP, 0, 0, 0, 0),
         mk(CMD_SUB, -32768, -32768, 32767, 32767),
         mk(CMD_DUMP, 0, 0, 0, 0),
         mk(CMD_CLEAR, 0, 0, 0, 0),
         mk(CMD_DUMP, 0, 0, 0, 0)
      };
      foreach (directed[i]) send(directed[i], 1);
      // Fill the list with a grid, then punch holes to force overflow.
      for (int i = 0; i < 34; i++) send(mk(CMD_ADD, (i % 6) * 10, (i / 6) * 10, 10, 10), 1);
      for (int i = 0; i < 4; i++) send(mk(CMD_SUB, 3 + i * 10, 3, 4, 30), 1);
      send(mk(CMD_DUMP, 0, 0, 0, 0), 1);
      // Typed-in check: the model predicts done with no entries for this clear.
      send(mk(CMD_CLEAR, 0, 0, 0, 0), 1);
      req_valid <= 1'b0;
      fixed = '0; fixed.kind = KIND_DONE; fixed.last = 1'b1;
      if (rsp_expected[$] !== fixed) begin
         $display("%0t: mismatch expected %h actual %h", $realtime, fixed, rsp_expected[$]);
         errors++;
      end
      // Sender pause until the block has drained.
      while (rsp_expected.size() != 0) @(negedge clock);
      // Long receiver hold while requests keep coming.
      hold_rsp = 1'b1;
      fork
         begin
            repeat (LongHold) @(negedge clock);
            hold_rsp = 1'b0;
         end
         for (int i = 0; i < 8; i++) send(rand_req(), 0);
      join
      for (int i = 0; i < RandItems; i++) begin
         if (i == RandItems - 40) idle_off = 1'b1;
         send(rand_req(), 1);
      end
      req_valid <= 1'b0;
      while (rsp_expected.size() != 0) @(negedge clock);
      repeat (300) @(negedge clock);
      if (errors == 0 && rsp_expected.size() == 0)
         $display("tb_clip_rect_list_subtract: PASS");
      else
         $display("tb_clip_rect_list_subtract: FAIL");
      $finish;
   end

endmodule

`default_nettype wire
